/* src/dedup_message_ring_top_assert.svh */
// assertion macros shared by the ring design
`ifndef DEDUP_MESSAGE_RING_TOP_ASSERT_SVH
`define DEDUP_MESSAGE_RING_TOP_ASSERT_SVH

// same-cycle implication under reset
`define DMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define DMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/dmr_pkg.sv */
package dmr_pkg;

	localparam int MSG_BYTES   = 32;
	localparam int MSG_W       = MSG_BYTES * 8;
	localparam int KEY_W       = 2 * MSG_W;
	localparam int DEPTH_DEF   = 16;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int MODE_W      = 2;
	localparam int IN_TDATA_W  = 264;
	localparam int OUT_TDATA_W = 264;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [STATUS_W-1:0] STATUS_NOT_OK = 2'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_LOOKUP = 2'd2,
		MODE_SET    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_RD,
		ST_KEY,
		ST_CMP,
		ST_DONE
	} state_t;

	// zero every byte after the first zero byte
	function automatic logic [MSG_W-1:0] cut_msg(input logic [MSG_W-1:0] m);
		logic             ended;
		logic [MSG_W-1:0] r;
		ended = 1'b0;
		r     = '0;
		for (int k = 0; k < MSG_BYTES; k++) begin
			if (!ended) begin
				r[8*k +: 8] = m[8*k +: 8];
			end
			if (m[8*k +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

/* src/dmr_key_unit.sv */
// key extraction: prefix before first comma, suffix from first colon after it
module dmr_key_unit import dmr_pkg::*; (
	input  logic [MSG_W-1:0] msg,
	output logic [KEY_W-1:0] key
);

	logic [MSG_W-1:0] pfx;
	logic [MSG_W-1:0] sfx;
	logic             seen_comma;
	logic             found_colon;
	logic [4:0]       colon_pos;

	// prefix mask and colon search in one pass over the bytes
	always_comb begin
		pfx         = '0;
		seen_comma  = 1'b0;
		found_colon = 1'b0;
		colon_pos   = '0;
		for (int k = 0; k < MSG_BYTES; k++) begin
			if (!found_colon && seen_comma && msg[8*k +: 8] == CHAR_COLON) begin
				found_colon = 1'b1;
				colon_pos   = 5'(k);
			end
			if (msg[8*k +: 8] == CHAR_COMMA) begin
				seen_comma = 1'b1;
			end
			if (!seen_comma) begin
				pfx[8*k +: 8] = msg[8*k +: 8];
			end
		end
	end

	// suffix moved down to byte zero
	assign sfx = found_colon ? (msg >> {colon_pos, 3'b000}) : '0;
	assign key = {sfx, pfx};

endmodule

/* src/dmr_msg_ram.sv */
// message store, one row per slot, registered read
module dmr_msg_ram import dmr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] waddr,
	input  logic [MSG_W-1:0] wdata,
	input  logic [PTR_W-1:0] raddr,
	output logic [MSG_W-1:0] rdata
);

	logic [MSG_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/dedup_message_ring_top.sv */
// channel   dir  tdata fields (low bit up)                               tuser
// s_axis    in   msg_w0..msg_w3, new_status                              mode
// m_axis    out  done_res, slot, out_w0..out_w3, is_empty, is_full       -
//
// push runs EXEC then DONE; pop adds POP (skipped on an empty ring); lookup
// and set-status run RD, KEY, CMP per entry scanned, and a last RD when none matches
// the scan runs one stored entry at a time through the shared key unit
// (memory read, key extraction, key compare)
// arst_n clears the pointers and control; the stores are not cleared
// one item at a time; a finished result waits in the output register
// while the next item may already be accepted
module dedup_message_ring_top import dmr_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// msg_w0, msg_w1, msg_w2, msg_w3, new_status, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [MODE_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// done_res, slot, out_w0, out_w1, out_w2, out_w3, is_empty, is_full, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	`include "dedup_message_ring_top_assert.svh"

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	state_t state_q, state_d;

	mode_t            mode_q;
	logic [MSG_W-1:0] msg_q;
	logic [STATUS_W-1:0] nstat_q;
	logic [KEY_W-1:0] want_q;
	logic [KEY_W-1:0] have_q;
	logic [KEY_W-1:0] key;
	logic [MSG_W-1:0] key_src;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, idx_q;
	logic [PTR_W-1:0] raddr;
	logic [MSG_W-1:0] rdata;
	logic [MSG_W-1:0] res_q;
	logic             found_q;
	logic [PTR_W-1:0] slot_q;
	logic             out_valid_q;
	logic [OUT_TDATA_W-1:0] out_q;
	logic             ram_we;
	logic             is_empty, is_full;
	logic [STATUS_W-1:0] status_mem [DEPTH];

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	assign is_empty = (rd_ptr_q == wr_ptr_q);
	assign is_full  = (next_slot(wr_ptr_q) == rd_ptr_q);

	// shared key unit: input message first, then each stored entry
	assign key_src = (state_q == ST_EXEC) ? msg_q : rdata;

	dmr_key_unit u_key (
		.msg (key_src),
		.key (key)
	);

	assign ram_we = (state_q == ST_EXEC) && (mode_q == MODE_PUSH);
	assign raddr  = (state_q == ST_EXEC) ? rd_ptr_q : idx_q;

	dmr_msg_ram #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (msg_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		s_axis_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (mode_q)
					MODE_PUSH:   state_d = ST_DONE;
					MODE_POP:    state_d = is_empty ? ST_DONE : ST_POP;
					MODE_LOOKUP,
					MODE_SET:    state_d = ST_RD;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_POP: state_d = ST_DONE;
			ST_RD:  state_d = (idx_q == wr_ptr_q) ? ST_DONE : ST_KEY;
			ST_KEY: state_d = ST_CMP;
			ST_CMP: state_d = (have_q == want_q) ? ST_DONE : ST_RD;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// pointers and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a finished result or drain the taken one
			if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					found_q <= (mode_q == MODE_PUSH);
					if (mode_q == MODE_PUSH) begin
						if (is_full) rd_ptr_q <= next_slot(rd_ptr_q);
						wr_ptr_q <= next_slot(wr_ptr_q);
					end
				end
				ST_POP: begin
					rd_ptr_q <= next_slot(rd_ptr_q);
					found_q  <= 1'b1;
				end
				ST_CMP: begin
					if (have_q == want_q) found_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			mode_q  <= mode_t'(s_axis_tuser);
			msg_q   <= cut_msg(s_axis_tdata[MSG_W-1:0]);
			nstat_q <= s_axis_tdata[MSG_W +: STATUS_W];
		end
		unique case (state_q)
			ST_EXEC: begin
				want_q <= key;
				idx_q  <= rd_ptr_q;
				res_q  <= '0;
				slot_q <= '0;
			end
			ST_POP: res_q  <= rdata;
			ST_KEY: have_q <= key;
			ST_CMP: begin
				if (have_q == want_q) slot_q <= idx_q;
				else idx_q <= next_slot(idx_q);
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_q <= {1'b0, is_full, is_empty, res_q,
						SLOT_W'(slot_q), found_q};
				end
			end
			default: ;
		endcase
	end

	// resend status store
	always_ff @(posedge clk) begin
		if (ram_we) begin
			status_mem[wr_ptr_q] <= STATUS_NOT_OK;
		end else if (state_q == ST_CMP && mode_q == MODE_SET && have_q == want_q) begin
			status_mem[idx_q] <= nstat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`DMR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready high right after accept")
	`DMR_ASSERT_NEXT(a_push_not_empty, state_q == ST_EXEC && mode_q == MODE_PUSH, rd_ptr_q != wr_ptr_q, "ring empty after push")
	`DMR_ASSERT_NOW(a_cmp_in_range, state_q == ST_CMP, idx_q != wr_ptr_q, "compare beyond newest entry")

endmodule
